[src/dhks_pkg.sv]
// Package for the double-hashed key set: hash constants, slot and opcode codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package dhks_pkg;

	// Default table geometry. The slot count must be a power of two.
	localparam int TABLE_SLOTS_DEF = 1024;
	localparam int MAX_KEY_CHARS   = 8;

	// First hash: polynomial with base 31 modulo 1e9+9.
	localparam logic [29:0] HASH_MOD  = 30'd1000000009;
	localparam logic [4:0]  HASH_BASE = 5'd31;
	// Characters are offset so that 'a' maps to one.
	localparam logic [9:0]  CHAR_OFS  = 10'd96;
	// Most negative character term magnitude (signed byte -128 minus 96).
	localparam int          NEG_TERM_MAX = 224;
	// Number of conditional subtract steps to reduce one first-hash sum.
	localparam int          RED_STEPS = 8;

	// Second hash: multiplier 137, reduced by digits of four bits.
	localparam int H2_DIGIT_BITS = 4;
	localparam int H2_STEPS      = 64 / H2_DIGIT_BITS;

	// Residue of 2^64 modulo the first-hash modulus, used when the 64-bit sum wraps.
	function automatic longint unsigned wrap_residue();
		longint unsigned r;
		r = 64'd1;
		for (int i = 0; i < 64; i++) begin
			r = (r * 64'd2) % 64'd1000000009;
		end
		return r;
	endfunction

	// Bias added to a negative signed sum: the wrap residue plus enough moduli to go positive.
	localparam logic [37:0] NEG_BIAS =
		38'(wrap_residue() + 64'(NEG_TERM_MAX) * 64'd1000000009);

	// Request opcodes. The unused code answers fail.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DEL    = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Slot states.
	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_KEY     = 2'd1;
	localparam logic [1:0] ST_DELETED = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_REDUCE,
		S_MOD,
		S_READ,
		S_EVAL,
		S_RESP
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic hash;
		logic reduce;
		logic modstep;
		logic advance;
		logic note_del;
		logic store;
		logic mark_del;
		logic set_result;
		logic result;
		logic rsp_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic chars_done;
		logic reduce_last;
		logic mod_last;
		logic op_add;
		logic op_del;
		logic op_find;
		logic slot_empty;
		logic slot_match;
		logic slot_deleted;
		logic seen_del;
		logic probe_last;
		logic rsp_free;
	} dp_sts_t;

endpackage

[src/dhks_datapath.sv]
// Datapath of the key set: key capture, both hashes, probe address walk,
// slot memories and the result register. Depends on dhks_pkg.
module dhks_datapath #(
	parameter int TABLE_SLOTS = dhks_pkg::TABLE_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dhks_pkg::dp_cmd_t cmd,
	input  logic [1:0]        opcode,
	input  logic [63:0]       key_chars,
	input  logic [3:0]        key_length,
	input  logic              rsp_stall,
	output dhks_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	output logic              ok
);
	localparam int SW = $clog2(TABLE_SLOTS);
	localparam logic [SW:0] DIV2 = (SW + 1)'(TABLE_SLOTS - 1);

	// Control registers.
	logic [SW-1:0] clr_q;
	logic [3:0]    char_q;
	logic [2:0]    step_q;
	logic [3:0]    mcnt_q;
	logic [SW-1:0] probe_cnt_q;
	logic          seen_del_q;
	logic          rsp_valid_q;

	// Payload registers.
	logic [1:0]    op_q;
	logic [63:0]   key_q;
	logic [3:0]    len_q;
	logic [63:0]   kc_q;
	logic [29:0]   h1_q;
	logic [29:0]   p_q;
	logic [37:0]   y_q;
	logic [37:0]   pp_q;
	logic [63:0]   h2_q;
	logic [SW-1:0] r2_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] stride_q;
	logic [SW-1:0] del_idx_q;
	logic          result_q;
	logic          ok_q;

	// Slot memories and their registered read data.
	logic [1:0]  stat_mem [TABLE_SLOTS];
	logic [67:0] row_mem  [TABLE_SLOTS];
	logic [1:0]  stat_rd_q;
	logic [67:0] row_rd_q;

	logic [3:0]         len_sat;
	logic [63:0]        key_m;
	logic [7:0]         cb;
	logic signed [9:0]  term;
	logic signed [40:0] prod;
	logic signed [41:0] sum_v;
	logic [37:0]        y_new;
	logic [37:0]        pp_new;
	logic [63:0]        h2_new;
	logic [37:0]        cmp;
	logic [37:0]        y_red;
	logic [37:0]        pp_red;
	logic [SW:0]        r_acc;
	logic [SW-1:0]      r2_next;
	logic [SW-1:0]      stride_new;
	logic [SW-1:0]      tgt;
	logic               st_we;
	logic [SW-1:0]      st_wa;
	logic [1:0]         st_wd;

	// Length saturation and masking of the bytes beyond the length.
	always_comb begin
		len_sat = (key_length > 4'(dhks_pkg::MAX_KEY_CHARS)) ?
			4'(dhks_pkg::MAX_KEY_CHARS) : key_length;
		for (int j = 0; j < 8; j++) begin
			key_m[8*j +: 8] = (4'(j) < len_sat) ? key_chars[8*j +: 8] : 8'h00;
		end
	end

	// One character step of both hashes; the character is taken as a signed byte.
	always_comb begin
		cb     = kc_q[7:0];
		term   = signed'({cb[7], cb[7], cb}) - signed'(dhks_pkg::CHAR_OFS);
		prod   = term * signed'({1'b0, p_q});
		sum_v  = signed'({12'b0, h1_q}) + prod;
		y_new  = sum_v[41] ? 38'(sum_v + signed'({4'b0, dhks_pkg::NEG_BIAS})) : sum_v[37:0];
		pp_new = 38'({8'b0, p_q} * 38'(dhks_pkg::HASH_BASE));
		h2_new = (h2_q << 7) + (h2_q << 3) + h2_q + {{56{cb[7]}}, cb};
	end

	// One conditional subtract of the modulus, scaled by the step, on both sums.
	always_comb begin
		cmp    = 38'(dhks_pkg::HASH_MOD) << step_q;
		y_red  = (y_q >= cmp) ? y_q - cmp : y_q;
		pp_red = (pp_q >= cmp) ? pp_q - cmp : pp_q;
	end

	// Four bits per cycle of the second hash reduction, most significant first.
	always_comb begin
		r_acc = {1'b0, r2_q};
		for (int j = 0; j < dhks_pkg::H2_DIGIT_BITS; j++) begin
			r_acc = {r_acc[SW-1:0], h2_q[63-j]};
			if (r_acc >= DIV2) begin
				r_acc = r_acc - DIV2;
			end
		end
		r2_next    = r_acc[SW-1:0];
		stride_new = r2_next[0] ? r2_next : r2_next + SW'(1);
	end

	// Slot state write: clearing pass, insert, or deletion mark.
	always_comb begin
		tgt   = seen_del_q ? del_idx_q : idx_q;
		st_we = cmd.clear | cmd.store | cmd.mark_del;
		priority if (cmd.clear) begin
			st_wa = clr_q;
			st_wd = dhks_pkg::ST_EMPTY;
		end else if (cmd.store) begin
			st_wa = tgt;
			st_wd = dhks_pkg::ST_KEY;
		end else begin
			st_wa = idx_q;
			st_wd = dhks_pkg::ST_DELETED;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			stat_mem[st_wa] <= st_wd;
		end
		stat_rd_q <= stat_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			row_mem[tgt] <= {len_q, key_q};
		end
		row_rd_q <= row_mem[idx_q];
	end

	// Counters, flags and the result beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			char_q      <= '0;
			step_q      <= '0;
			mcnt_q      <= '0;
			probe_cnt_q <= '0;
			seen_del_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + SW'(1);
			end
			if (cmd.load) begin
				char_q <= '0;
				mcnt_q <= '0;
			end
			if (cmd.hash) begin
				char_q <= char_q + 4'd1;
				step_q <= 3'(dhks_pkg::RED_STEPS - 1);
			end
			if (cmd.reduce) begin
				step_q <= step_q - 3'd1;
			end
			if (cmd.modstep) begin
				mcnt_q <= mcnt_q + 4'd1;
				if (sts.mod_last) begin
					probe_cnt_q <= '0;
					seen_del_q  <= 1'b0;
				end
			end
			if (cmd.advance) begin
				probe_cnt_q <= probe_cnt_q + SW'(1);
			end
			if (cmd.note_del) begin
				seen_del_q <= 1'b1;
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Key, hash and probe payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= key_m;
			kc_q  <= key_m;
			len_q <= len_sat;
			h1_q  <= '0;
			p_q   <= 30'd1;
			h2_q  <= '0;
			r2_q  <= '0;
		end
		if (cmd.hash) begin
			y_q  <= y_new;
			pp_q <= pp_new;
			h2_q <= h2_new;
			kc_q <= kc_q >> 8;
		end
		if (cmd.reduce) begin
			y_q  <= y_red;
			pp_q <= pp_red;
			if (step_q == 3'd0) begin
				h1_q <= y_red[29:0];
				p_q  <= pp_red[29:0];
			end
		end
		if (cmd.modstep) begin
			r2_q <= r2_next;
			h2_q <= h2_q << dhks_pkg::H2_DIGIT_BITS;
			if (sts.mod_last) begin
				stride_q <= stride_new;
				idx_q    <= h1_q[SW-1:0];
			end
		end
		if (cmd.advance) begin
			idx_q <= idx_q + stride_q;
		end
		if (cmd.note_del) begin
			del_idx_q <= idx_q;
		end
		if (cmd.set_result) begin
			result_q <= cmd.result;
		end
		if (cmd.rsp_load) begin
			ok_q <= result_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.clear_last   = (clr_q == SW'(TABLE_SLOTS - 1));
		sts.chars_done   = (char_q == len_q);
		sts.reduce_last  = (step_q == 3'd0);
		sts.mod_last     = (mcnt_q == 4'(dhks_pkg::H2_STEPS - 1));
		sts.op_add       = (op_q == dhks_pkg::OP_ADD);
		sts.op_del       = (op_q == dhks_pkg::OP_DEL);
		sts.op_find      = (op_q == dhks_pkg::OP_FIND);
		sts.slot_empty   = (stat_rd_q == dhks_pkg::ST_EMPTY);
		sts.slot_deleted = (stat_rd_q == dhks_pkg::ST_DELETED);
		sts.slot_match   = (stat_rd_q == dhks_pkg::ST_KEY) && (row_rd_q == {len_q, key_q});
		sts.seen_del     = seen_del_q;
		sts.probe_last   = (probe_cnt_q == SW'(TABLE_SLOTS - 1));
		sts.rsp_free     = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign ok        = ok_q;

endmodule

[src/dhks_ctrl.sv]
// Controller of the key set: sequences clearing, hashing, probing and the result beat.
// Depends on dhks_pkg.
module dhks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  dhks_pkg::dp_sts_t sts,
	output logic              req_stall,
	output dhks_pkg::dp_cmd_t cmd
);
	dhks_pkg::ctl_state_t state_q;
	dhks_pkg::ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhks_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			dhks_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_nxt = dhks_pkg::S_IDLE;
				end
			end
			dhks_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = dhks_pkg::S_HASH;
				end
			end
			dhks_pkg::S_HASH: begin
				if (sts.chars_done) begin
					state_nxt = dhks_pkg::S_MOD;
				end else begin
					cmd.hash  = 1'b1;
					state_nxt = dhks_pkg::S_REDUCE;
				end
			end
			dhks_pkg::S_REDUCE: begin
				cmd.reduce = 1'b1;
				if (sts.reduce_last) begin
					state_nxt = dhks_pkg::S_HASH;
				end
			end
			dhks_pkg::S_MOD: begin
				cmd.modstep = 1'b1;
				if (sts.mod_last) begin
					state_nxt = dhks_pkg::S_READ;
				end
			end
			dhks_pkg::S_READ: begin
				// The unused opcode fails without touching the table.
				if (sts.op_add || sts.op_del || sts.op_find) begin
					state_nxt = dhks_pkg::S_EVAL;
				end else begin
					cmd.set_result = 1'b1;
					state_nxt      = dhks_pkg::S_RESP;
				end
			end
			dhks_pkg::S_EVAL: begin
				state_nxt = dhks_pkg::S_RESP;
				if (sts.op_add) begin
					// Insert at the first deleted slot seen, else at the first empty one.
					if (sts.slot_empty) begin
						cmd.store      = 1'b1;
						cmd.set_result = 1'b1;
						cmd.result     = 1'b1;
					end else if (sts.slot_match) begin
						cmd.set_result = 1'b1;
					end else begin
						cmd.note_del = sts.slot_deleted && !sts.seen_del;
						if (sts.probe_last) begin
							cmd.store      = sts.seen_del || sts.slot_deleted;
							cmd.set_result = 1'b1;
							cmd.result     = sts.seen_del || sts.slot_deleted;
						end else begin
							cmd.advance = 1'b1;
							state_nxt   = dhks_pkg::S_READ;
						end
					end
				end else begin
					if (sts.slot_empty) begin
						cmd.set_result = 1'b1;
					end else if (sts.slot_match) begin
						cmd.mark_del   = sts.op_del;
						cmd.set_result = 1'b1;
						cmd.result     = 1'b1;
					end else if (sts.probe_last) begin
						cmd.set_result = 1'b1;
					end else begin
						cmd.advance = 1'b1;
						state_nxt   = dhks_pkg::S_READ;
					end
				end
			end
			dhks_pkg::S_RESP: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_nxt    = dhks_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dhks_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[src/double_hash_key_set.sv]
// Top level of the double-hashed key set: controller plus datapath.
// Depends on dhks_pkg, dhks_ctrl and dhks_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  request  | req_valid, req_stall | opcode, key_chars, key_length
//  result   | rsp_valid, rsp_stall | ok
//
// After reset a clearing pass marks every slot empty; requests are stalled during it.
// A request goes through its steps in order: each character is multiplied into the
// first hash and then reduced by conditional subtracts of the modulus, the second hash
// is reduced four bits a cycle, and each probe reads the slot memories and then
// evaluates the slot. The next request can be taken in the same cycle as the result
// beat is first offered.
// One request is worked on at a time; the next is taken while the result beat waits.
module double_hash_key_set #(
	parameter int TABLE_SLOTS = dhks_pkg::TABLE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_chars,
	input  logic [3:0]  key_length,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        ok
);
	dhks_pkg::dp_cmd_t cmd;
	dhks_pkg::dp_sts_t sts;

	dhks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	dhks_datapath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.key_chars  (key_chars),
		.key_length (key_length),
		.rsp_stall  (rsp_stall),
		.sts        (sts),
		.rsp_valid  (rsp_valid),
		.ok         (ok)
	);

endmodule

[src/dhks_checker.sv]
// Port-level checks for the double-hashed key set, bound to the top level.
// Depends on double_hash_key_set.
module dhks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [1:0]  opcode,
	input logic [63:0] key_chars,
	input logic [3:0]  key_length,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        ok
);
	// A stalled result beat stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its value.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(ok))
		else $error("result changed while stalled");

	// After a request beat the block is busy with it.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken before the first finished");

	// A new result beat only appears out of a busy period.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without work");

endmodule

bind double_hash_key_set dhks_checker u_dhks_checker (.*);
